[sv/ftws_pkg.sv]
// Shared constants, types and state encoding for the frame time window statistics block.
package ftws_pkg;

	localparam int WINDOW      = 64;
	localparam int ADDR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W       = $clog2(WINDOW + 1);
	localparam int DUR_W       = 32;
	localparam int SUM_W       = DUR_W + CNT_W;
	localparam int TS_W        = 64;
	localparam int FRAME_W     = 64;
	localparam int WCOUNT_W    = 7;
	localparam int IN_TDATA_W  = 2 * TS_W;
	localparam int RESULT_W    = 4 * DUR_W + WCOUNT_W + FRAME_W;
	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DUR,
		ST_WRITE,
		ST_SCAN,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [FRAME_W-1:0]  frame_number;
		logic [WCOUNT_W-1:0] window_count;
		logic [DUR_W-1:0]    max_ns;
		logic [DUR_W-1:0]    min_ns;
		logic [DUR_W-1:0]    mean_ns;
		logic [DUR_W-1:0]    frame_duration_ns;
	} result_t;

endpackage

[sv/ftws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ftws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[sv/ftws_div.sv]
// Restoring serial divider: one quotient bit per cycle for the window mean.
module ftws_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ftws_pkg::SUM_W-1:0]    dividend,
	input  logic [ftws_pkg::CNT_W-1:0]    divisor,
	output logic                          done,
	output logic [ftws_pkg::SUM_W-1:0]    quotient
);

	localparam int STEP_W = $clog2(ftws_pkg::SUM_W);

	logic                          busy_q;
	logic                          done_q;
	logic [STEP_W-1:0]             step_q;
	logic [ftws_pkg::SUM_W-1:0]    quo_q;
	logic [ftws_pkg::CNT_W-1:0]    rem_q;
	logic [ftws_pkg::CNT_W-1:0]    div_q;
	logic [ftws_pkg::CNT_W:0]      rem_shift;
	logic [ftws_pkg::CNT_W+1:0]    diff;
	logic                          ge;

	assign rem_shift = {rem_q, quo_q[ftws_pkg::SUM_W-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, div_q};
	assign ge        = ~diff[ftws_pkg::CNT_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(ftws_pkg::SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ftws_pkg::SUM_W-2:0], ge};
			rem_q <= ge ? diff[ftws_pkg::CNT_W-1:0] : rem_shift[ftws_pkg::CNT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/frame_time_window_stats.sv]
// Sliding window min / max / mean of frame durations over a ring of WINDOW samples.
// A frame rescans the ring RAM one entry per cycle, then runs the one-bit-per-cycle divider.
// s_tready stays low while a frame is at work, so a new frame is taken only once the last
// result is loaded into the output stage. A clear transaction is handled in the idle state
// and leaves s_tready high. Reset empties the window, counters and output stage and sets
// enable; ring contents are not cleared, only entries below the fill count are read.
module frame_time_window_stats (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_data,      // enable
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ftws_pkg::IN_TDATA_W-1:0]      s_tdata,       // frame_start_ns, frame_end_ns
	input  logic                                 s_tuser,       // kind
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ftws_pkg::OUT_TDATA_W-1:0]     m_tdata        // frame_duration_ns, mean_ns,
	                                                            // min_ns, max_ns, window_count,
	                                                            // frame_number, zero pad
);

	ftws_pkg::state_t              state_q, state_d;
	logic                          enable_q;
	logic [ftws_pkg::TS_W-1:0]     start_q;
	logic [ftws_pkg::TS_W-1:0]     end_q;
	logic [ftws_pkg::DUR_W-1:0]    dur_q;
	logic [ftws_pkg::ADDR_W-1:0]   wr_pos_q;
	logic [ftws_pkg::CNT_W-1:0]    filled_q;
	logic [ftws_pkg::FRAME_W-1:0]  frame_q;
	logic [ftws_pkg::CNT_W-1:0]    issue_q;
	logic                          rd_v_s1;
	logic [ftws_pkg::SUM_W-1:0]    sum_q;
	logic [ftws_pkg::DUR_W-1:0]    min_q;
	logic [ftws_pkg::DUR_W-1:0]    max_q;
	logic [ftws_pkg::DUR_W-1:0]    mean_q;
	ftws_pkg::result_t             out_q;
	logic                          m_tvalid_q;

	logic                          accept;
	logic                          issue;
	logic                          scan_end;
	logic                          load_out;
	logic [ftws_pkg::TS_W:0]       diff;
	logic [ftws_pkg::DUR_W-1:0]    dur_calc;
	logic [ftws_pkg::DUR_W-1:0]    rd_data;
	logic                          div_done;
	logic [ftws_pkg::SUM_W-1:0]    quotient;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ftws_pkg::ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign issue     = (state_q == ftws_pkg::ST_SCAN) && (issue_q != filled_q);
	assign scan_end  = (state_q == ftws_pkg::ST_SCAN) && (issue_q == filled_q) && !rd_v_s1;
	assign load_out  = (state_q == ftws_pkg::ST_OUT) && (!m_tvalid_q || m_tready);

	assign diff     = {1'b0, end_q} - {1'b0, start_q};
	assign dur_calc = diff[ftws_pkg::TS_W] ? '0 :
	                  (|diff[ftws_pkg::TS_W-1:ftws_pkg::DUR_W]) ? '1 :
	                  diff[ftws_pkg::DUR_W-1:0];

	ftws_ram #(
		.WIDTH(ftws_pkg::DUR_W),
		.DEPTH(ftws_pkg::WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (state_q == ftws_pkg::ST_WRITE),
		.wr_addr (wr_pos_q),
		.wr_data (dur_q),
		.rd_en   (issue),
		.rd_addr (issue_q[ftws_pkg::ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	ftws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (scan_end),
		.dividend (sum_q),
		.divisor  (filled_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ftws_pkg::ST_IDLE: begin
				if (accept && s_tuser == ftws_pkg::KIND_FRAME && enable_q) begin
					state_d = ftws_pkg::ST_DUR;
				end
			end
			ftws_pkg::ST_DUR:   state_d = ftws_pkg::ST_WRITE;
			ftws_pkg::ST_WRITE: state_d = ftws_pkg::ST_SCAN;
			ftws_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = ftws_pkg::ST_DIV;
				end
			end
			ftws_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = ftws_pkg::ST_OUT;
				end
			end
			ftws_pkg::ST_OUT: begin
				if (load_out) begin
					state_d = ftws_pkg::ST_IDLE;
				end
			end
			default: state_d = ftws_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ftws_pkg::ST_IDLE;
			enable_q   <= 1'b1;
			wr_pos_q   <= '0;
			filled_q   <= '0;
			frame_q    <= '0;
			issue_q    <= '0;
			rd_v_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				enable_q <= cfg_data;
			end
			if (accept && s_tuser == ftws_pkg::KIND_CLEAR) begin
				wr_pos_q <= '0;
				filled_q <= '0;
				frame_q  <= '0;
			end
			if (state_q == ftws_pkg::ST_WRITE) begin
				wr_pos_q <= (wr_pos_q == ftws_pkg::ADDR_W'(ftws_pkg::WINDOW - 1)) ?
				            '0 : wr_pos_q + ftws_pkg::ADDR_W'(1);
				if (filled_q != ftws_pkg::CNT_W'(ftws_pkg::WINDOW)) begin
					filled_q <= filled_q + ftws_pkg::CNT_W'(1);
				end
				frame_q <= frame_q + ftws_pkg::FRAME_W'(1);
				issue_q <= '0;
			end else if (issue) begin
				issue_q <= issue_q + ftws_pkg::CNT_W'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= s_tdata[ftws_pkg::TS_W-1:0];
			end_q   <= s_tdata[ftws_pkg::IN_TDATA_W-1:ftws_pkg::TS_W];
		end
		if (state_q == ftws_pkg::ST_DUR) begin
			dur_q <= dur_calc;
		end
		if (state_q == ftws_pkg::ST_WRITE) begin
			sum_q <= '0;
			min_q <= '1;
			max_q <= '0;
		end else if (rd_v_s1) begin
			sum_q <= sum_q + ftws_pkg::SUM_W'(rd_data);
			if (rd_data < min_q) begin
				min_q <= rd_data;
			end
			if (rd_data > max_q) begin
				max_q <= rd_data;
			end
		end
		if (div_done) begin
			mean_q <= quotient[ftws_pkg::DUR_W-1:0];
		end
		if (load_out) begin
			out_q.frame_duration_ns <= dur_q;
			out_q.mean_ns           <= mean_q;
			out_q.min_ns            <= min_q;
			out_q.max_ns            <= max_q;
			out_q.window_count      <= ftws_pkg::WCOUNT_W'(filled_q);
			out_q.frame_number      <= frame_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = ftws_pkg::OUT_TDATA_W'(out_q);

endmodule

[sv/ftws_checker.sv]
// Port-level checks for the frame time window statistics block, bound to the top level.
module ftws_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [ftws_pkg::OUT_TDATA_W-1:0]  m_tdata
);

	ftws_pkg::result_t r;

	assign r = ftws_pkg::result_t'(m_tdata[ftws_pkg::RESULT_W-1:0]);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> r.window_count != '0 &&
		             r.window_count <= ftws_pkg::WCOUNT_W'(ftws_pkg::WINDOW))
		else $error("window count out of range");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> r.min_ns <= r.mean_ns && r.mean_ns <= r.max_ns &&
		             r.min_ns <= r.frame_duration_ns && r.frame_duration_ns <= r.max_ns)
		else $error("min, mean, max and duration out of order");

	a_clear_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ftws_pkg::KIND_CLEAR |=> s_tready)
		else $error("clear transaction did not finish in one cycle");

endmodule

bind frame_time_window_stats ftws_checker u_ftws_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
